// ===== hw/rtl/dd_pkg.sv =====
// widths, types and calendar tables for the date difference block
`default_nettype none

package dd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 22;
  localparam int DN_W   = 23;
  localparam int Q_W    = 8;

  localparam int MAX_YEAR_DEF = 9999;

  localparam int DAYS_PER_YEAR = 365;
  localparam int CENTURY       = 100;
  localparam int RECIP_W       = 13;
  localparam int RECIP_100     = 5243;
  localparam int RECIP_SH      = 19;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
  localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
  localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

  typedef struct packed {
    logic [DAY_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    logic [YEAR_W-1:0] py;
    logic [DN_W-1:0]   py365;
    logic [Q_W-1:0]    qy;
    logic              range_ok;
  } s1_date_t;

  typedef struct packed {
    logic [DAY_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [DN_W-1:0]   base;
    logic [Q_W-1:0]    qp;
    logic              leap;
    logic              ok;
  } s2_date_t;

  typedef struct packed {
    logic [DN_W-1:0] dn;
    logic            ok;
  } s3_date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                   len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      default:                len = DAY_W'(31);
    endcase
    return len;
  endfunction

  function automatic logic [DN_W-1:0] days_before(input logic [MON_W-1:0] m);
    logic [DN_W-1:0] n;
    case (m)
      4'd2:    n = DN_W'(31);
      4'd3:    n = DN_W'(59);
      4'd4:    n = DN_W'(90);
      4'd5:    n = DN_W'(120);
      4'd6:    n = DN_W'(151);
      4'd7:    n = DN_W'(181);
      4'd8:    n = DN_W'(212);
      4'd9:    n = DN_W'(243);
      4'd10:   n = DN_W'(273);
      4'd11:   n = DN_W'(304);
      4'd12:   n = DN_W'(334);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/date_difference_in_days.sv =====
// date difference in days: four-stage pipeline from two dates to a day count
// throughput: one word per cycle while out_stall does not hold the output, set by the single global pipeline enable
// an output stall freezes every stage; in_stall follows it while out_valid is high
// reset: synchronous active-low rst_n clears all stage valid bits, payload is not reset
`default_nettype none

module date_difference_in_days #(
  parameter int MAX_YEAR = dd_pkg::MAX_YEAR_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dd_pkg::DAY_W-1:0]    in_start_day,
  input  wire logic [dd_pkg::MON_W-1:0]    in_start_month,
  input  wire logic [dd_pkg::YEAR_W-1:0]   in_start_year,
  input  wire logic [dd_pkg::DAY_W-1:0]    in_end_day,
  input  wire logic [dd_pkg::MON_W-1:0]    in_end_month,
  input  wire logic [dd_pkg::YEAR_W-1:0]   in_end_year,
  input  wire logic                        in_include_end,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dd_pkg::CNT_W-1:0]         out_day_count,
  output logic                             out_date_invalid
);

  import dd_pkg::*;

  localparam logic [YEAR_W:0] MaxYear = (YEAR_W+1)'(MAX_YEAR);
  localparam int PROD_W = YEAR_W + RECIP_W;

  logic advance;

  logic     v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, vo_r, vo_nxt;
  logic     inc1_r, inc2_r, inc3_r;
  s1_date_t s1_r [2];
  s1_date_t s1_nxt [2];
  s2_date_t s2_r [2];
  s2_date_t s2_nxt [2];
  s3_date_t s3_r [2];
  s3_date_t s3_nxt [2];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bad_r, bad_nxt;

  logic [DAY_W-1:0]  in_d [2];
  logic [MON_W-1:0]  in_m [2];
  logic [YEAR_W-1:0] in_y [2];

  assign advance  = !vo_r || !out_stall;
  assign in_stall = !advance;

  assign in_d[0] = in_start_day;
  assign in_m[0] = in_start_month;
  assign in_y[0] = in_start_year;
  assign in_d[1] = in_end_day;
  assign in_m[1] = in_end_month;
  assign in_y[1] = in_end_year;

  // stage 1: year minus one, that times 365, year over 100, range checks
  always_comb begin
    logic [PROD_W-1:0] prod;
    for (int i = 0; i < 2; i++) begin
      prod                 = PROD_W'(in_y[i]) * PROD_W'(RECIP_100);
      s1_nxt[i].d          = in_d[i];
      s1_nxt[i].m          = in_m[i];
      s1_nxt[i].y          = in_y[i];
      s1_nxt[i].py         = in_y[i] - YEAR_W'(1);
      s1_nxt[i].py365      = DN_W'(s1_nxt[i].py) * DN_W'(DAYS_PER_YEAR);
      s1_nxt[i].qy         = prod[RECIP_SH +: Q_W];
      s1_nxt[i].range_ok   = (in_y[i] != '0) && ({1'b0, in_y[i]} <= MaxYear) &&
                             (in_m[i] >= MON_JAN) && (in_m[i] <= MON_DEC);
    end
  end

  // stage 2: leap rule, day check, partial day number
  always_comb begin
    logic cent;
    for (int i = 0; i < 2; i++) begin
      cent = (YEAR_W'(s1_r[i].qy) * YEAR_W'(CENTURY)) == s1_r[i].y;
      s2_nxt[i].d    = s1_r[i].d;
      s2_nxt[i].m    = s1_r[i].m;
      s2_nxt[i].base = s1_r[i].py365 + DN_W'(s1_r[i].py >> 2);
      s2_nxt[i].qp   = cent ? s1_r[i].qy - Q_W'(1) : s1_r[i].qy;
      s2_nxt[i].leap = ((s1_r[i].y[1:0] == 2'b00) && !cent) ||
                       (cent && (s1_r[i].qy[1:0] == 2'b00));
      s2_nxt[i].ok   = s1_r[i].range_ok && (s1_r[i].d != '0) &&
                       (s1_r[i].d <= month_len(s1_r[i].m, s2_nxt[i].leap));
    end
  end

  // stage 3: full day number
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      s3_nxt[i].dn = s2_r[i].base - DN_W'(s2_r[i].qp) + DN_W'(s2_r[i].qp >> 2) +
                     days_before(s2_r[i].m) +
                     DN_W'((s2_r[i].m > MON_FEB) && s2_r[i].leap) + DN_W'(s2_r[i].d);
      s3_nxt[i].ok = s2_r[i].ok;
    end
  end

  // stage 4: difference (zero unless end is after start), include flag, saturation, zero count for invalid dates
  always_comb begin
    logic [DN_W:0] sum;
    sum = (s3_r[0].dn < s3_r[1].dn) ? {1'b0, s3_r[1].dn - s3_r[0].dn} : '0;
    sum = sum + (DN_W+1)'(inc3_r);
    bad_nxt = !(s3_r[0].ok && s3_r[1].ok);
    if (bad_nxt) begin
      cnt_nxt = '0;
    end else if (sum[DN_W:CNT_W] != '0) begin
      cnt_nxt = COUNT_MAX;
    end else begin
      cnt_nxt = sum[CNT_W-1:0];
    end
  end

  always_comb begin
    v1_nxt = advance ? in_valid : v1_r;
    v2_nxt = advance ? v1_r : v2_r;
    v3_nxt = advance ? v2_r : v3_r;
    vo_nxt = advance ? v3_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      s3_r   <= s3_nxt;
      inc1_r <= in_include_end;
      inc2_r <= inc1_r;
      inc3_r <= inc2_r;
      cnt_r  <= cnt_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid        = vo_r;
  assign out_day_count    = cnt_r;
  assign out_date_invalid = bad_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_invalid |-> out_day_count == '0)
    else $error("invalid date word carries a nonzero count");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled output word");

  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !in_stall |=> out_valid)
    else $error("word lost between last stage and output");

endmodule

`default_nettype wire
